// ===== rtl/core/nearest_passable_cell_search_assert.svh =====
// Assertion macros used by the checker module of the passable cell search.
// Include guard only; no other dependencies.
`ifndef NEAREST_PASSABLE_CELL_SEARCH_ASSERT_SVH
`define NEAREST_PASSABLE_CELL_SEARCH_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define NPCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/npcs_pkg.sv =====
// Types and constants of the nearest passable cell search block.
// No dependencies; imported by the top level and the checker.
package npcs_pkg;

  localparam int unsigned CoordW  = 6;
  localparam int unsigned GridCfgW = 7;
  localparam int unsigned RadiusW = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEARCH_RADIUS = 2'd2;

  localparam logic [GridCfgW-1:0] GRID_WIDTH_RST    = 7'd64;
  localparam logic [GridCfgW-1:0] GRID_HEIGHT_RST   = 7'd64;
  localparam logic [RadiusW-1:0]  SEARCH_RADIUS_RST = 6'd8;

  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic              cell_passable;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] result_x;
    logic [CoordW-1:0] result_y;
  } res_t;

endpackage

// ===== rtl/core/npcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module npcs_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/nearest_passable_cell_search.sv =====
// Nearest passable cell search. A write request updates the bitmap and gives no result.
// A search visits ring 0 (the start cell), then rings 1, 2 and so on, one bitmap read per
// cycle in ST_SCAN, with ST_WAIT after each ring settling its last read, up to the first
// ring with a passable cell or the search radius. The single read port sets this rate.
// After reset the bitmap is cleared one cell per cycle (MAX_GRID_W * MAX_GRID_H cells,
// 4096 by default) with busy_o high. Results are strobed on done_o for one cycle.
module nearest_passable_cell_search #(
  parameter int unsigned MAX_GRID_W = 64,
  parameter int unsigned MAX_GRID_H = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  npcs_pkg::req_t                  req_i,
  output logic                            busy_o,
  output logic                            done_o,
  output npcs_pkg::res_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [npcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [npcs_pkg::CfgDataW-1:0]   cfg_data_i
);
  import npcs_pkg::*;

  localparam int unsigned Depth = MAX_GRID_W * MAX_GRID_H;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CapW  = (MAX_GRID_W > 127) ? 127 : MAX_GRID_W;
  localparam int unsigned CapH  = (MAX_GRID_H > 127) ? 127 : MAX_GRID_H;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] x, input logic [6:0] y);
    logic [AW+7:0] lin;
    lin = (AW+8)'(y) * (AW+8)'(MAX_GRID_W) + (AW+8)'(x);
    return lin[AW-1:0];
  endfunction

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;
  logic [GridCfgW-1:0]   cfg_w_q, cfg_h_q;
  logic [RadiusW-1:0]    cfg_r_q;
  logic [GridCfgW-1:0]   eff_w, eff_h;

  logic [CoordW-1:0]     sx_q, sx_d, sy_q, sy_d;
  logic [RadiusW-1:0]    r_q, r_d, r_next;
  logic signed [6:0]     dx_q, dx_d, dy_q, dy_d;
  logic signed [6:0]     rs, rs_neg, rn_neg;

  logic signed [7:0]     cx, cy;
  logic                  inb;
  logic [6:0]            adx, ady, man_dist;

  logic                  pv_q, pv_d, pinb_q;
  logic [6:0]            pd_q;
  logic [CoordW-1:0]     px_q, py_q;

  logic                  best_found_q, best_found_d;
  logic [6:0]            best_d_q, best_d_d;
  logic [CoordW-1:0]     best_x_q, best_x_d, best_y_q, best_y_d;

  logic                  done_q, done_d;
  res_t                  res_q, res_d;

  logic                  accept, wr_inb, hit;
  logic                  ram_we, ram_wdata, ram_re, ram_rdata;
  logic [AW-1:0]         ram_waddr, ram_raddr;

  assign eff_w = (cfg_w_q > 7'(CapW)) ? 7'(CapW) : cfg_w_q;
  assign eff_h = (cfg_h_q > 7'(CapH)) ? 7'(CapH) : cfg_h_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign wr_inb = ({1'b0, req_i.pos_x} < eff_w) && ({1'b0, req_i.pos_y} < eff_h);

  // Current scan position relative to the start, and the ring bounds.
  assign rs     = $signed({1'b0, r_q});
  assign rs_neg = -rs;
  assign r_next = r_q + 1'b1;
  assign rn_neg = -$signed({1'b0, r_next});

  assign cx  = $signed({2'b00, sx_q}) + $signed({dx_q[6], dx_q});
  assign cy  = $signed({2'b00, sy_q}) + $signed({dy_q[6], dy_q});
  assign inb = !cx[7] && !cy[7] && (cx[6:0] < eff_w) && (cy[6:0] < eff_h);
  assign adx = dx_q[6] ? 7'(-dx_q) : 7'(dx_q);
  assign ady = dy_q[6] ? 7'(-dy_q) : 7'(dy_q);
  assign man_dist = adx + ady;

  // Bitmap port: clearing sweep or request writes, scan reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_q;
    ram_wdata = 1'b0;
    if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && (req_i.kind == KIND_WRITE) && wr_inb) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr({1'b0, req_i.pos_x}, {1'b0, req_i.pos_y});
      ram_wdata = req_i.cell_passable;
    end
  end

  assign ram_re    = (state_q == ST_SCAN);
  assign ram_raddr = inb ? cell_addr(cx[6:0], cy[6:0]) : '0;

  npcs_ram #(
    .WIDTH(1),
    .DEPTH(Depth)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Evaluation of the cell read in the previous cycle. A strict compare keeps
  // the earliest cell in scan order on equal Manhattan distance.
  assign hit = pv_q && pinb_q && ram_rdata;

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    r_d          = r_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    pv_d         = 1'b0;
    best_found_d = best_found_q;
    best_d_d     = best_d_q;
    best_x_d     = best_x_q;
    best_y_d     = best_y_q;
    done_d       = 1'b0;
    res_d        = res_q;

    if (hit && (!best_found_q || (pd_q < best_d_q))) begin
      best_found_d = 1'b1;
      best_d_d     = pd_q;
      best_x_d     = px_q;
      best_y_d     = py_q;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (req_i.kind == KIND_SEARCH)) begin
          sx_d         = req_i.pos_x;
          sy_d         = req_i.pos_y;
          r_d          = '0;
          dx_d         = '0;
          dy_d         = '0;
          best_found_d = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pv_d = 1'b1;
        if ((dx_q == rs) && (dy_q == rs)) begin
          state_d = ST_WAIT;
        end else if (dx_q == rs) begin
          dy_d = dy_q + 7'sd1;
          dx_d = rs_neg;
        end else if ((dy_q == rs_neg) || (dy_q == rs)) begin
          dx_d = dx_q + 7'sd1;
        end else begin
          // Inner rows of a ring hold only the two side cells.
          dx_d = rs;
        end
      end
      ST_WAIT: begin
        if (best_found_d || (r_q == cfg_r_q)) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (best_found_d) begin
            res_d = '{found: 1'b1, result_x: best_x_d, result_y: best_y_d};
          end else begin
            res_d = '{found: 1'b0, result_x: sx_q, result_y: sy_q};
          end
        end else begin
          r_d     = r_next;
          dx_d    = rn_neg;
          dy_d    = rn_neg;
          state_d = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      r_q          <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      pv_q         <= 1'b0;
      best_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      sx_q         <= sx_d;
      sy_q         <= sy_d;
      r_q          <= r_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      pv_q         <= pv_d;
      best_found_q <= best_found_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= GRID_WIDTH_RST;
      cfg_h_q <= GRID_HEIGHT_RST;
      cfg_r_q <= SEARCH_RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH:    cfg_w_q <= cfg_data_i[GridCfgW-1:0];
        CFG_GRID_HEIGHT:   cfg_h_q <= cfg_data_i[GridCfgW-1:0];
        CFG_SEARCH_RADIUS: cfg_r_q <= cfg_data_i[RadiusW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Side band of the read in flight and result payload.
  always_ff @(posedge clk_i) begin
    pinb_q   <= inb;
    pd_q     <= man_dist;
    px_q     <= cx[CoordW-1:0];
    py_q     <= cy[CoordW-1:0];
    best_d_q <= best_d_d;
    best_x_q <= best_x_d;
    best_y_q <= best_y_d;
    res_q    <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/npcs_chk.sv =====
// Port-level checker for the nearest passable cell search, bound to the top level.
// Depends on npcs_pkg and nearest_passable_cell_search_assert.svh.
`include "nearest_passable_cell_search_assert.svh"

module npcs_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input npcs_pkg::req_t req_i,
  input logic           busy_i,
  input logic           done_i
);
  import npcs_pkg::*;

  logic search_req, write_req;

  assign search_req = start_i && !busy_i && (req_i.kind == KIND_SEARCH);
  assign write_req  = start_i && !busy_i && (req_i.kind == KIND_WRITE);

  // A search request sets busy in the cycle after it is taken.
  `NPCS_ASSERT_NEXT(a_search_busy, clk_i, rst_ni, search_req, busy_i, "search request did not set busy")
  // A write request completes at once and never produces a result.
  `NPCS_ASSERT_NEXT(a_write_quiet, clk_i, rst_ni, write_req, !busy_i && !done_i, "write request left block busy or gave a result")
  // The block is free again while its result is shown.
  `NPCS_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_i, !busy_i, "result shown while busy")
  // Each search gives a single one-cycle result.
  `NPCS_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_i, !done_i, "result strobe held for two cycles")

endmodule

bind nearest_passable_cell_search npcs_chk u_npcs_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .req_i  (req_i),
  .busy_i (busy_o),
  .done_i (done_o)
);
